// ----- rtl/mte_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mte_pkg
// Shared types, constants and triangle tables of the tetrahedron surface
// extractor.
// ============================================================================
package mte_pkg;

    localparam int KEY_TABLE_DEPTH  = 4096;
    localparam int KT_ADDR_BITS     = $clog2(KEY_TABLE_DEPTH);
    localparam int MESH_VERTEX_BITS = 16;
    localparam int SURFACE_ID_BITS  = 20;
    localparam int HASH_MULT        = 40503;
    localparam int QUEUE_DEPTH      = 4;
    localparam int Q_PTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int IN_DATA_BITS     = 144;
    localparam int OUT_DATA_BITS    = 168;
    localparam int OUT_USER_BITS    = 3;

    localparam logic [SURFACE_ID_BITS-1:0] ID_MAX = {SURFACE_ID_BITS{1'b1}};

    typedef struct packed {
        logic signed [31:0]          val;
        logic signed [31:0]          x;
        logic signed [31:0]          y;
        logic signed [31:0]          z;
        logic [MESH_VERTEX_BITS-1:0] mv;
    } vtx_src_t;

    typedef struct packed {
        vtx_src_t c0;
        vtx_src_t c1;
        logic     tri_end;
        logic     tetra_end;
    } ref_t;

    typedef struct packed {
        logic                        valid;
        logic [MESH_VERTEX_BITS-1:0] lo;
        logic [MESH_VERTEX_BITS-1:0] hi;
        logic [SURFACE_ID_BITS-1:0]  id;
    } key_entry_t;

    typedef struct packed {
        logic [SURFACE_ID_BITS-1:0]  id;
        logic                        is_new;
        logic signed [31:0]          x;
        logic signed [31:0]          y;
        logic signed [31:0]          z;
        logic [MESH_VERTEX_BITS-1:0] first;
        logic [MESH_VERTEX_BITS-1:0] second;
        logic [15:0]                 frac;
        logic                        tri_end;
        logic                        tetra_end;
        logic                        ovf;
    } out_item_t;

    typedef enum logic [1:0] {
        FR_COLLECT,
        FR_CODE,
        FR_CLASS,
        FR_EMIT
    } front_state_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SETUP,
        BK_ABS,
        BK_PREP,
        BK_DIV,
        BK_MUL,
        BK_ADD,
        BK_RD,
        BK_CHK,
        BK_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_BM0,
        COND_BM1,
        COND_BM2,
        COND_BM3
    } tri_cond_t;

    localparam logic [2:0] SYM_V0 = 3'd0;
    localparam logic [2:0] SYM_V1 = 3'd1;
    localparam logic [2:0] SYM_V2 = 3'd2;
    localparam logic [2:0] SYM_V3 = 3'd3;
    localparam logic [2:0] SYM_W0 = 3'd4;
    localparam logic [2:0] SYM_W1 = 3'd5;
    localparam logic [2:0] SYM_W2 = 3'd6;
    localparam logic [2:0] SYM_W3 = 3'd7;

    localparam logic [1:0] PC_ONE   = 2'd0;
    localparam logic [1:0] PC_TWO   = 2'd1;
    localparam logic [1:0] PC_THREE = 2'd2;
    localparam logic [1:0] PC_FOUR  = 2'd3;

    typedef struct packed {
        tri_cond_t  cond;
        logic [2:0] s0;
        logic [2:0] s1;
        logic [2:0] s2;
    } tri_spec_t;

    // corner order per code, packed {m3, m2, m1, m0}
    localparam logic [7:0] REMAP [16] = '{
        8'hE4, 8'hE4, 8'hC9, 8'hE4, 8'hD2, 8'h78, 8'hC9, 8'h1B,
        8'h1B, 8'h9C, 8'h2D, 8'hD2, 8'h4E, 8'hC9, 8'hE4, 8'hE4
    };

    // crossing edges of the two-inside case, packed {j3, j2, j1, j0}
    localparam logic [7:0] CROSS_A = 8'h50;
    localparam logic [7:0] CROSS_B = 8'hEB;

    function automatic logic [1:0] pick(input logic [7:0] m, input logic [1:0] k);
        logic [1:0] r;
        case (k)
            2'd0:    r = m[1:0];
            2'd1:    r = m[3:2];
            2'd2:    r = m[5:4];
            default: r = m[7:6];
        endcase
        return r;
    endfunction

    function automatic tri_spec_t mk(input tri_cond_t c, input logic [2:0] a,
                                     input logic [2:0] b, input logic [2:0] d);
        tri_spec_t r;
        r = '{c, a, b, d};
        return r;
    endfunction

    function automatic tri_spec_t tri_spec(input logic [1:0] pc, input logic [2:0] slot);
        tri_spec_t r;
        case ({pc, slot})
            {PC_FOUR, 3'd0}:  r = mk(COND_BM0, SYM_V1, SYM_V2, SYM_V3);
            {PC_FOUR, 3'd1}:  r = mk(COND_BM1, SYM_V3, SYM_V2, SYM_V0);
            {PC_FOUR, 3'd2}:  r = mk(COND_BM2, SYM_V1, SYM_V3, SYM_V0);
            {PC_FOUR, 3'd3}:  r = mk(COND_BM3, SYM_V2, SYM_V1, SYM_V0);
            {PC_ONE, 3'd0}:   r = mk(COND_ALWAYS, SYM_W0, SYM_W1, SYM_W2);
            {PC_ONE, 3'd1}:   r = mk(COND_BM1, SYM_W1, SYM_V0, SYM_W2);
            {PC_ONE, 3'd2}:   r = mk(COND_BM2, SYM_W2, SYM_V0, SYM_W0);
            {PC_ONE, 3'd3}:   r = mk(COND_BM3, SYM_W0, SYM_V0, SYM_W1);
            {PC_TWO, 3'd0}:   r = mk(COND_ALWAYS, SYM_W0, SYM_W2, SYM_W1);
            {PC_TWO, 3'd1}:   r = mk(COND_ALWAYS, SYM_W0, SYM_W3, SYM_W2);
            {PC_TWO, 3'd2}:   r = mk(COND_BM0, SYM_V1, SYM_W2, SYM_W3);
            {PC_TWO, 3'd3}:   r = mk(COND_BM1, SYM_V0, SYM_W0, SYM_W1);
            {PC_TWO, 3'd4}:   r = mk(COND_BM2, SYM_V1, SYM_W3, SYM_W0);
            {PC_TWO, 3'd5}:   r = mk(COND_BM2, SYM_V1, SYM_W0, SYM_V0);
            {PC_TWO, 3'd6}:   r = mk(COND_BM3, SYM_V0, SYM_W1, SYM_W2);
            {PC_TWO, 3'd7}:   r = mk(COND_BM3, SYM_V0, SYM_W2, SYM_V1);
            {PC_THREE, 3'd0}: r = mk(COND_ALWAYS, SYM_W2, SYM_W1, SYM_W0);
            {PC_THREE, 3'd1}: r = mk(COND_BM0, SYM_V1, SYM_V2, SYM_V3);
            {PC_THREE, 3'd2}: r = mk(COND_BM1, SYM_V2, SYM_W1, SYM_W2);
            {PC_THREE, 3'd3}: r = mk(COND_BM1, SYM_V2, SYM_W2, SYM_V3);
            {PC_THREE, 3'd4}: r = mk(COND_BM2, SYM_V3, SYM_W2, SYM_W0);
            {PC_THREE, 3'd5}: r = mk(COND_BM2, SYM_V3, SYM_W0, SYM_V1);
            {PC_THREE, 3'd6}: r = mk(COND_BM3, SYM_V1, SYM_W0, SYM_W1);
            {PC_THREE, 3'd7}: r = mk(COND_BM3, SYM_V1, SYM_W1, SYM_V2);
            default:          r = mk(COND_NEVER, SYM_V0, SYM_V0, SYM_V0);
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/marching_tetra_surface_extract.sv -----
`timescale 1ns / 1ps
// ============================================================================
// marching_tetra_surface_extract
// Tetrahedron iso-surface extractor with cap triangles and an edge-key table
// that deduplicates surface vertices.
// ============================================================================
// Corner items are taken one per cycle while collecting; the fourth starts the
// code and classify states, then one vertex reference per cycle enters a
// four-deep queue while it is not full. Each reference passes setup, absolute
// values, the bit-serial divider if its fraction needs it, a multiply and add
// per axis, key-table probes and the output hand-off, one at a time.
// After reset a clearing pass sweeps all 4096 key-table entries; no corner item
// is taken until it ends. Configuration writes are taken at any time.
module marching_tetra_surface_extract
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // corner_value, corner_x, corner_y, corner_z, mesh_vertex
    input  logic [mte_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // face_on_boundary
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // surface_vertex_id, out_x, out_y, out_z, edge_first, edge_second,
    // edge_fraction, zero fill
    output logic [mte_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // is_new_vertex, triangle_end, overflow
    output logic [mte_pkg::OUT_USER_BITS-1:0]  m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [31:0]                        cfg_data
);
    import mte_pkg::*;

    logic signed [31:0] thr_reg;
    vtx_src_t           in_corner;
    ref_t               push_ref;
    ref_t               q_head;
    out_item_t          out_item;
    logic               push_valid;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic               clear_busy;

    assign cfg_ready     = 1'b1;
    assign in_corner.val = s_tdata[31:0];
    assign in_corner.x   = s_tdata[63:32];
    assign in_corner.y   = s_tdata[95:64];
    assign in_corner.z   = s_tdata[127:96];
    assign in_corner.mv  = s_tdata[143:128];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 32'sd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    mte_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_corner  (in_corner),
        .in_bnd     (s_tuser[0]),
        .enable     (!clear_busy),
        .thr        (thr_reg),
        .push_valid (push_valid),
        .push_ref   (push_ref),
        .push_full  (q_full)
    );

    mte_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_ref),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    mte_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .thr        (thr_reg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (out_item)
    );

    assign m_tdata = {4'd0, out_item.frac, out_item.second, out_item.first,
                      out_item.z, out_item.y, out_item.x, out_item.id};
    assign m_tuser = {out_item.ovf, out_item.tri_end, out_item.is_new};
    assign m_tlast = out_item.tetra_end;

endmodule

// ----- rtl/mte_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mte_front
// Collects four corner items, classifies the tetrahedron and issues one
// vertex reference per cycle towards the reference queue while it is not full.
// ============================================================================
module mte_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mte_pkg::vtx_src_t  in_corner,
    input  logic               in_bnd,
    input  logic               enable,
    input  logic signed [31:0] thr,
    output logic               push_valid,
    output mte_pkg::ref_t      push_ref,
    input  logic               push_full
);
    import mte_pkg::*;

    front_state_t state_reg, state_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [2:0]   slot_reg, slot_next;
    logic [1:0]   vtx_reg, vtx_next;
    logic         pend_valid_reg, pend_valid_next;

    vtx_src_t           corner_mem [4];
    logic signed [31:0] val_reg [4];
    logic [3:0]         bnd_reg;
    logic [3:0]         code_reg;
    logic [1:0]         pc_reg;
    logic [7:0]         m_reg;
    logic [7:0]         mask_reg;
    ref_t               pend_reg;

    logic       accept;
    logic [1:0] pc_cls;
    logic [7:0] m_cls;
    logic [7:0] mask_cls;
    tri_spec_t  spec;
    tri_spec_t  spec_cls;
    logic       slot_en;
    logic       last_slot;
    logic       issue;
    logic [2:0] sym;
    logic [1:0] ia;
    logic [1:0] ib;

    assign in_ready   = (state_reg == FR_COLLECT) && enable;
    assign accept     = in_ready && in_valid;
    assign push_valid = pend_valid_reg;
    assign push_ref   = pend_reg;

    always_comb
    begin
        pc_cls   = 2'($countones(code_reg) - 1);
        m_cls    = REMAP[code_reg];
        mask_cls = 8'd0;
        spec_cls = mk(COND_NEVER, SYM_V0, SYM_V0, SYM_V0);
        for (int s = 0; s < 8; s++)
        begin
            spec_cls = tri_spec(pc_cls, 3'(s));
            case (spec_cls.cond)
                COND_ALWAYS: mask_cls[s] = 1'b1;
                COND_BM0:    mask_cls[s] = bnd_reg[pick(m_cls, 2'd0)];
                COND_BM1:    mask_cls[s] = bnd_reg[pick(m_cls, 2'd1)];
                COND_BM2:    mask_cls[s] = bnd_reg[pick(m_cls, 2'd2)];
                COND_BM3:    mask_cls[s] = bnd_reg[pick(m_cls, 2'd3)];
                default:     mask_cls[s] = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        spec      = tri_spec(pc_reg, slot_reg);
        slot_en   = mask_reg[slot_reg];
        last_slot = (mask_reg & ~((8'd2 << slot_reg) - 8'd1)) == 8'd0;
        case (vtx_reg)
            2'd0:    sym = spec.s0;
            2'd1:    sym = spec.s1;
            default: sym = spec.s2;
        endcase
        if (!sym[2])
        begin
            ia = pick(m_reg, sym[1:0]);
            ib = ia;
        end
        else if (pc_reg == PC_TWO)
        begin
            ia = pick(m_reg, pick(CROSS_A, sym[1:0]));
            ib = pick(m_reg, pick(CROSS_B, sym[1:0]));
        end
        else
        begin
            ia = pick(m_reg, 2'd0);
            ib = pick(m_reg, sym[1:0] + 2'd1);
        end
    end

    assign issue = (state_reg == FR_EMIT) && slot_en && (!pend_valid_reg || !push_full);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        slot_next       = slot_reg;
        vtx_next        = vtx_reg;
        pend_valid_next = issue || (pend_valid_reg && push_full);
        case (state_reg)
            FR_COLLECT:
            begin
                if (accept)
                begin
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_next = FR_CODE;
                    end
                end
            end
            FR_CODE:
            begin
                state_next = FR_CLASS;
            end
            FR_CLASS:
            begin
                slot_next = 3'd0;
                vtx_next  = 2'd0;
                if (code_reg == 4'd0 || mask_cls == 8'd0)
                begin
                    state_next = FR_COLLECT;
                end
                else
                begin
                    state_next = FR_EMIT;
                end
            end
            FR_EMIT:
            begin
                if (!slot_en)
                begin
                    slot_next = slot_reg + 3'd1;
                end
                else if (issue)
                begin
                    if (vtx_reg == 2'd2)
                    begin
                        vtx_next  = 2'd0;
                        slot_next = slot_reg + 3'd1;
                        if (last_slot)
                        begin
                            state_next = FR_COLLECT;
                        end
                    end
                    else
                    begin
                        vtx_next = vtx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = FR_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FR_COLLECT;
            cnt_reg        <= 2'd0;
            slot_reg       <= 3'd0;
            vtx_reg        <= 2'd0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            slot_reg       <= slot_next;
            vtx_reg        <= vtx_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            corner_mem[cnt_reg] <= in_corner;
            val_reg[cnt_reg]    <= in_corner.val;
            bnd_reg[cnt_reg]    <= in_bnd;
        end
        if (state_reg == FR_CODE)
        begin
            for (int j = 0; j < 4; j++)
            begin
                code_reg[j] <= val_reg[j] < thr;
            end
        end
        if (state_reg == FR_CLASS)
        begin
            pc_reg   <= pc_cls;
            m_reg    <= m_cls;
            mask_reg <= mask_cls;
        end
        if (issue)
        begin
            pend_reg.c0        <= corner_mem[ia];
            pend_reg.c1        <= corner_mem[ib];
            pend_reg.tri_end   <= vtx_reg == 2'd2;
            pend_reg.tetra_end <= (vtx_reg == 2'd2) && last_slot;
        end
    end

endmodule

// ----- rtl/mte_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mte_queue
// Short first-in first-out queue of vertex references between front and back.
// ============================================================================
module mte_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mte_pkg::ref_t push_data,
    output logic          full,
    input  logic          pop,
    output mte_pkg::ref_t head,
    output logic          empty
);
    import mte_pkg::*;

    ref_t                slot_mem [QUEUE_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_BITS:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = count_reg == (Q_PTR_BITS+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = slot_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (Q_PTR_BITS+1)'(do_push) - (Q_PTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/mte_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mte_back
// Interpolates each vertex reference, deduplicates it in the edge-key table
// and holds the finished result item until it is taken.
// ============================================================================
module mte_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] thr,
    input  logic               q_empty,
    input  mte_pkg::ref_t      q_head,
    output logic               q_pop,
    output logic               clear_busy,
    output logic               out_valid,
    input  logic               out_ready,
    output mte_pkg::out_item_t out_item
);
    import mte_pkg::*;

    back_state_t                state_reg, state_next;
    logic [3:0]                 div_cnt_reg, div_cnt_next;
    logic [1:0]                 axis_reg, axis_next;
    logic [KT_ADDR_BITS-1:0]    probe_addr_reg, probe_addr_next;
    logic [KT_ADDR_BITS-1:0]    probe_cnt_reg, probe_cnt_next;
    logic [KT_ADDR_BITS-1:0]    clr_addr_reg, clr_addr_next;
    logic [SURFACE_ID_BITS-1:0] next_id_reg, next_id_next;

    key_entry_t key_mem [KEY_TABLE_DEPTH];
    key_entry_t rd_entry;

    ref_t                        cur_reg;
    logic signed [32:0]          num_reg;
    logic signed [32:0]          den_reg;
    logic [32:0]                 an_reg;
    logic [32:0]                 ad_reg;
    logic signed [32:0]          d_reg [3];
    logic [MESH_VERTEX_BITS-1:0] lo_reg;
    logic [MESH_VERTEX_BITS-1:0] hi_reg;
    logic [KT_ADDR_BITS-1:0]     home_reg;
    logic [15:0]                 u_reg;
    logic [32:0]                 rem_reg;
    logic signed [49:0]          prod_reg;
    logic signed [31:0]          pos_reg [3];
    out_item_t                   out_reg;

    logic                        mem_we;
    logic [KT_ADDR_BITS-1:0]     mem_waddr;
    key_entry_t                  mem_wdata;
    logic                        chk_done;
    out_item_t                   out_next;
    logic [33:0]                 div_sh;
    logic                        div_ge;
    logic [31:0]                 hash_sum;
    logic signed [31:0]          p0_sel;
    logic [MESH_VERTEX_BITS-1:0] lo_c;
    logic [MESH_VERTEX_BITS-1:0] hi_c;
    logic                        hit;

    assign clear_busy = state_reg == BK_CLEAR;
    assign q_pop      = (state_reg == BK_IDLE) && !q_empty;
    assign out_valid  = state_reg == BK_OUT;
    assign out_item   = out_reg;

    assign div_sh = {rem_reg, 1'b0};
    assign div_ge = div_sh >= {1'b0, ad_reg};
    assign hit    = rd_entry.valid && rd_entry.lo == lo_reg && rd_entry.hi == hi_reg;

    always_comb
    begin
        if (cur_reg.c0.mv < cur_reg.c1.mv)
        begin
            lo_c = cur_reg.c0.mv;
            hi_c = cur_reg.c1.mv;
        end
        else
        begin
            lo_c = cur_reg.c1.mv;
            hi_c = cur_reg.c0.mv;
        end
        hash_sum = 32'(lo_c) * 32'(HASH_MULT) + 32'(hi_c);
        case (axis_reg)
            2'd0:    p0_sel = cur_reg.c0.x;
            2'd1:    p0_sel = cur_reg.c0.y;
            default: p0_sel = cur_reg.c0.z;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        div_cnt_next    = div_cnt_reg;
        axis_next       = axis_reg;
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        clr_addr_next   = clr_addr_reg;
        next_id_next    = next_id_reg;
        mem_we          = 1'b0;
        mem_waddr       = probe_addr_reg;
        mem_wdata       = '0;
        chk_done        = 1'b0;
        out_next.id        = ID_MAX;
        out_next.is_new    = 1'b0;
        out_next.x         = pos_reg[0];
        out_next.y         = pos_reg[1];
        out_next.z         = pos_reg[2];
        out_next.first     = cur_reg.c0.mv;
        out_next.second    = cur_reg.c1.mv;
        out_next.frac      = u_reg;
        out_next.tri_end   = cur_reg.tri_end;
        out_next.tetra_end = cur_reg.tetra_end;
        out_next.ovf       = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_SETUP;
                end
            end
            BK_SETUP:
            begin
                state_next = BK_ABS;
            end
            BK_ABS:
            begin
                state_next = BK_PREP;
            end
            BK_PREP:
            begin
                div_cnt_next = 4'd0;
                axis_next    = 2'd0;
                if (ad_reg == '0 || an_reg >= ad_reg)
                begin
                    state_next = BK_MUL;
                end
                else
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_ADD;
            end
            BK_ADD:
            begin
                if (axis_reg == 2'd2)
                begin
                    probe_addr_next = home_reg;
                    probe_cnt_next  = '0;
                    state_next      = BK_RD;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = BK_MUL;
                end
            end
            BK_RD:
            begin
                state_next = BK_CHK;
            end
            BK_CHK:
            begin
                if (!rd_entry.valid)
                begin
                    chk_done = 1'b1;
                    if (next_id_reg == ID_MAX)
                    begin
                        out_next.ovf = 1'b1;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = '{1'b1, lo_reg, hi_reg, next_id_reg};
                        out_next.id     = next_id_reg;
                        out_next.is_new = 1'b1;
                        next_id_next    = next_id_reg + 1'b1;
                    end
                end
                else if (hit)
                begin
                    chk_done        = 1'b1;
                    out_next.id     = rd_entry.id;
                    out_next.x      = '0;
                    out_next.y      = '0;
                    out_next.z      = '0;
                    out_next.first  = '0;
                    out_next.second = '0;
                    out_next.frac   = '0;
                end
                else if (probe_cnt_reg == '1)
                begin
                    chk_done     = 1'b1;
                    out_next.ovf = 1'b1;
                end
                else
                begin
                    probe_addr_next = probe_addr_reg + 1'b1;
                    probe_cnt_next  = probe_cnt_reg + 1'b1;
                    state_next      = BK_RD;
                end
                if (chk_done)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            div_cnt_reg    <= 4'd0;
            axis_reg       <= 2'd0;
            probe_addr_reg <= '0;
            probe_cnt_reg  <= '0;
            clr_addr_reg   <= '0;
            next_id_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            div_cnt_reg    <= div_cnt_next;
            axis_reg       <= axis_next;
            probe_addr_reg <= probe_addr_next;
            probe_cnt_reg  <= probe_cnt_next;
            clr_addr_reg   <= clr_addr_next;
            next_id_reg    <= next_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        rd_entry <= key_mem[probe_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                cur_reg <= q_head;
            end
            BK_SETUP:
            begin
                num_reg  <= {thr[31], thr} - {cur_reg.c0.val[31], cur_reg.c0.val};
                den_reg  <= {cur_reg.c1.val[31], cur_reg.c1.val}
                            - {cur_reg.c0.val[31], cur_reg.c0.val};
                d_reg[0] <= {cur_reg.c1.x[31], cur_reg.c1.x} - {cur_reg.c0.x[31], cur_reg.c0.x};
                d_reg[1] <= {cur_reg.c1.y[31], cur_reg.c1.y} - {cur_reg.c0.y[31], cur_reg.c0.y};
                d_reg[2] <= {cur_reg.c1.z[31], cur_reg.c1.z} - {cur_reg.c0.z[31], cur_reg.c0.z};
                lo_reg   <= lo_c;
                hi_reg   <= hi_c;
                home_reg <= hash_sum[KT_ADDR_BITS-1:0];
            end
            BK_ABS:
            begin
                an_reg <= num_reg[32] ? 33'(-num_reg) : 33'(num_reg);
                ad_reg <= den_reg[32] ? 33'(-den_reg) : 33'(den_reg);
            end
            BK_PREP:
            begin
                rem_reg <= an_reg;
                if (ad_reg == '0)
                begin
                    u_reg <= 16'd0;
                end
                else if (an_reg >= ad_reg)
                begin
                    u_reg <= 16'hFFFF;
                end
                else
                begin
                    u_reg <= 16'd0;
                end
            end
            BK_DIV:
            begin
                rem_reg <= div_ge ? 33'(div_sh - {1'b0, ad_reg}) : div_sh[32:0];
                u_reg   <= {u_reg[14:0], div_ge};
            end
            BK_MUL:
            begin
                prod_reg <= d_reg[axis_reg] * $signed({1'b0, u_reg});
            end
            BK_ADD:
            begin
                pos_reg[axis_reg] <= p0_sel + prod_reg[47:16];
            end
            BK_CHK:
            begin
                if (chk_done)
                begin
                    out_reg <= out_next;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- rtl/mte_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mte_checker
// Port-level checks on the result stream of the surface extractor.
// ============================================================================
module mte_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mte_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input logic [mte_pkg::OUT_USER_BITS-1:0] m_tuser,
    input logic                              m_tlast
);
    import mte_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_ovf_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tdata[SURFACE_ID_BITS-1:0] == ID_MAX && !m_tuser[0])
        else $error("overflow item without reserved id");

    a_reuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] && !m_tuser[2] |-> m_tdata[163:20] == '0)
        else $error("reused vertex carries position data");

    a_tetra_tri: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("tetrahedron ends inside a triangle");

endmodule

bind marching_tetra_surface_extract mte_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
